// ===== sv/vertex_dedup_indexer_core_defines.svh =====
// Assertion helpers for the indexer core RTL.
`ifndef VERTEX_DEDUP_INDEXER_CORE_DEFINES_SVH
`define VERTEX_DEDUP_INDEXER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define VDI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vdi assertion failed");

// Next-cycle implication, checked outside reset
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vdi assertion failed");

`endif

// ===== sv/vdi_pkg.sv =====
package vdi_pkg;

    // Component layout of one corner
    localparam int NCOMP            = 8;
    localparam int CW               = 32;
    localparam int DW               = CW + 1;
    localparam int MAT_W            = 8;
    localparam int IDX_OUT_W        = 8;
    localparam int TOL_W            = 16;
    localparam int MAX_VERTICES_DEF = 256;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

    // Component order within t_vtx.comp
    localparam int C_POS_X    = 0;
    localparam int C_POS_Y    = 1;
    localparam int C_POS_Z    = 2;
    localparam int C_NORMAL_X = 3;
    localparam int C_NORMAL_Y = 4;
    localparam int C_NORMAL_Z = 5;
    localparam int C_TEX_U    = 6;
    localparam int C_TEX_V    = 7;

    typedef struct packed {
        logic [NCOMP-1:0][CW-1:0] comp;
        logic [MAT_W-1:0]         mat;
    } t_vtx;

    // Control that travels with a query down the chain
    typedef struct packed {
        logic valid;
        logic done;    // resolved by a hit or an append
        logic is_new;  // resolved by an append
    } t_qctl;

endpackage

// ===== sv/vdi_in_if.sv =====
interface vdi_in_if import vdi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CW-1:0]    pos_x;
    logic signed [CW-1:0]    pos_y;
    logic signed [CW-1:0]    pos_z;
    logic signed [CW-1:0]    normal_x;
    logic signed [CW-1:0]    normal_y;
    logic signed [CW-1:0]    normal_z;
    logic signed [CW-1:0]    tex_u;
    logic signed [CW-1:0]    tex_v;
    logic        [MAT_W-1:0] material_id;

    modport source (
        output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
               tex_u, tex_v, material_id,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
               tex_u, tex_v, material_id,
        output ready
    );
endinterface

// ===== sv/vdi_out_if.sv =====
interface vdi_out_if import vdi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] vertex_index;
    logic                 is_new;
    logic                 table_full;
    logic [MAT_W-1:0]     material_out;

    modport source (
        output valid, vertex_index, is_new, table_full, material_out,
        input  ready
    );
    modport sink (
        input  valid, vertex_index, is_new, table_full, material_out,
        output ready
    );
endinterface

// ===== sv/vertex_dedup_indexer_core.sv =====
// Each corner passes the MAX_VERTICES entry cells, then the output register.
// Throughput: one corner per cycle; each corner walks the chain of MAX_VERTICES
// entry cells, one cell per cycle, and a later corner sees every earlier append.
// Backpressure on the output stalls the whole chain, and the input with it.
// Reset (synchronous, active low): entries marked free, pipeline emptied,
// tolerance back to 655; stored vertex data is not cleared.
module vertex_dedup_indexer_core import vdi_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_wdata,
    vdi_in_if.sink           i_in,
    vdi_out_if.source        o_out
);

`include "vertex_dedup_indexer_core_defines.svh"

    localparam int IW = $clog2(MAX_VERTICES);

    logic [TOL_W-1:0]        r_tol;
    logic                    r_o_valid;
    logic [IDX_OUT_W-1:0]    r_o_idx;
    logic                    r_o_new;
    logic                    r_o_full;
    logic [MAT_W-1:0]        r_o_mat;
    logic                    adv;
    t_qctl                   w_ctl [0:MAX_VERTICES];
    t_vtx                    w_vtx [0:MAX_VERTICES];
    logic [IW-1:0]           w_idx [0:MAX_VERTICES];
    logic [MAX_VERTICES-1:0] w_used;
    logic [IW+IDX_OUT_W-1:0] idx_ext;
    t_qctl                   last_ctl;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Chain moves whenever the output register is free or being drained
    assign adv        = !r_o_valid || o_out.ready;
    assign i_in.ready = adv;

    // Chain head
    always_comb begin
        w_ctl[0]                   = '0;
        w_ctl[0].valid             = i_in.valid;
        w_vtx[0].comp[C_POS_X]     = i_in.pos_x;
        w_vtx[0].comp[C_POS_Y]     = i_in.pos_y;
        w_vtx[0].comp[C_POS_Z]     = i_in.pos_z;
        w_vtx[0].comp[C_NORMAL_X]  = i_in.normal_x;
        w_vtx[0].comp[C_NORMAL_Y]  = i_in.normal_y;
        w_vtx[0].comp[C_NORMAL_Z]  = i_in.normal_z;
        w_vtx[0].comp[C_TEX_U]     = i_in.tex_u;
        w_vtx[0].comp[C_TEX_V]     = i_in.tex_v;
        w_vtx[0].mat               = i_in.material_id;
        w_idx[0]                   = '0;
    end

    // Entry cells
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        vdi_cell #(
            .IW      (IW),
            .CELL_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tol   (r_tol),
            .i_ctl   (w_ctl[g]),
            .i_vtx   (w_vtx[g]),
            .i_idx   (w_idx[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_vtx   (w_vtx[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_used  (w_used[g])
        );
    end

    // A query leaving the chain unresolved found the table full
    assign last_ctl = w_ctl[MAX_VERTICES];
    assign idx_ext  = {{IDX_OUT_W{1'b0}}, w_idx[MAX_VERTICES]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= last_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_idx  <= last_ctl.done ? idx_ext[IDX_OUT_W-1:0] : '0;
            r_o_new  <= last_ctl.is_new;
            r_o_full <= !last_ctl.done;
            r_o_mat  <= w_vtx[MAX_VERTICES].mat;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.vertex_index = r_o_idx;
    assign o_out.is_new       = r_o_new;
    assign o_out.table_full   = r_o_full;
    assign o_out.material_out = r_o_mat;

    // Checks
    `VDI_ASSERT_NOW(a_new_xor_full, i_clk, i_rst_n, r_o_valid, !(r_o_new && r_o_full))
    `VDI_ASSERT_NOW(a_full_all_used, i_clk, i_rst_n, r_o_valid && r_o_full, &w_used)
    `VDI_ASSERT_NOW(a_used_packed, i_clk, i_rst_n, 1'b1, ((w_used >> 1) & ~w_used) == '0)
    `VDI_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_o_valid && !o_out.ready, r_o_valid && $stable(r_o_idx))
    `VDI_ASSERT_NOW(a_stall_blocks_in, i_clk, i_rst_n, r_o_valid && !o_out.ready, !i_in.ready)

endmodule

// ===== sv/vdi_cell.sv =====
// One table entry plus one stage of the query pipeline.
module vdi_cell import vdi_pkg::*; #(
    parameter int IW      = 8,
    parameter int CELL_ID = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [TOL_W-1:0] i_tol,
    input  t_qctl            i_ctl,
    input  t_vtx             i_vtx,
    input  logic [IW-1:0]    i_idx,
    output t_qctl            o_ctl,
    output t_vtx             o_vtx,
    output logic [IW-1:0]    o_idx,
    output logic             o_used
);

    logic                     r_used;
    logic                     n_used;
    logic [NCOMP-1:0][CW-1:0] r_entry;
    t_qctl                    r_ctl;
    t_qctl                    n_ctl;
    t_vtx                     r_vtx;
    logic [IW-1:0]            r_idx;
    logic [IW-1:0]            n_idx;
    logic                     store;
    logic [NCOMP-1:0]         close;
    logic                     all_close;
    logic                     open_query;

    // Per-component exact 33-bit distance against tolerance
    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            logic [DW-1:0] d;
            logic [DW-1:0] m;
            d = {i_vtx.comp[c][CW-1], i_vtx.comp[c]} - {r_entry[c][CW-1], r_entry[c]};
            m = d[DW-1] ? (~d + DW'(1)) : d;
            close[c] = (m < DW'(i_tol));
        end
    end

    assign all_close  = &close;
    assign open_query = i_ctl.valid && !i_ctl.done;

    // Resolve the query here on first hit or on reaching the first free entry
    always_comb begin
        n_ctl  = i_ctl;
        n_idx  = i_idx;
        n_used = r_used;
        store  = 1'b0;
        priority if (open_query && r_used && all_close) begin
            n_ctl.done = 1'b1;
            n_idx      = IW'(CELL_ID);
        end else if (open_query && !r_used) begin
            n_ctl.done   = 1'b1;
            n_ctl.is_new = 1'b1;
            n_idx        = IW'(CELL_ID);
            n_used       = 1'b1;
            store        = 1'b1;
        end else begin
            n_ctl = i_ctl;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_ctl  <= '0;
        end else if (i_adv) begin
            r_used <= n_used;
            r_ctl  <= n_ctl;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vtx <= i_vtx;
            r_idx <= n_idx;
            if (store) begin
                r_entry <= i_vtx.comp;
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_vtx  = r_vtx;
    assign o_idx  = r_idx;
    assign o_used = r_used;

endmodule

// ===== tb/vertex_dedup_checker.sv =====
module vertex_dedup_checker import vdi_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_wdata,
    vdi_in_if                i_corner,
    vdi_out_if               i_result,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_appends,
    output int               o_hits,
    output int               o_fulls
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] vertex_index;
        logic                 is_new;
        logic                 table_full;
        logic [MAT_W-1:0]     material_out;
    } t_index_result;

    // Shadow copy of the unique-vertex table and the tolerance register
    logic [CW-1:0]    uniq_store [MAX_VERTICES][NCOMP];
    int unsigned      uniq_count;
    logic [TOL_W-1:0] match_tol;
    t_index_result    index_queue [$];

    // Exact signed difference, so opposite extremes never wrap into a match
    function automatic bit comp_within(input logic [CW-1:0] a, input logic [CW-1:0] b);
        longint diff;
        diff = longint'($signed(a)) - longint'($signed(b));
        if (diff < 0)
            diff = -diff;
        return diff < longint'(match_tol);
    endfunction

    // First entry within tolerance wins; otherwise append, or flag a full table
    function automatic t_index_result resolve_corner(input t_vtx v);
        t_index_result r;
        bit            all_close;
        int            i;
        int            c;
        r.vertex_index = '0;
        r.is_new       = 1'b0;
        r.table_full   = 1'b0;
        r.material_out = v.mat;
        for (i = 0; i < uniq_count; i++) begin
            all_close = 1'b1;
            for (c = 0; c < NCOMP; c++)
                if (!comp_within(v.comp[c], uniq_store[i][c]))
                    all_close = 1'b0;
            if (all_close) begin
                r.vertex_index = IDX_OUT_W'(i);
                return r;
            end
        end
        if (uniq_count >= MAX_VERTICES) begin
            r.table_full = 1'b1;
            return r;
        end
        for (c = 0; c < NCOMP; c++)
            uniq_store[uniq_count][c] = v.comp[c];
        r.vertex_index = IDX_OUT_W'(uniq_count);
        r.is_new       = 1'b1;
        uniq_count++;
        return r;
    endfunction

    task automatic compare_field(input string field_name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
            o_fail_count++;
        end
    endtask

    // Monitor: register writes, result transfers, corner transfers
    always @(posedge i_clk) begin
        t_vtx          corner;
        t_index_result want;
        if (!i_rst_n) begin
            uniq_count = 0;
            match_tol  = TOL_RESET;
            index_queue.delete();
        end else begin
            if (i_cfg_we)
                match_tol = i_cfg_wdata;

            if (i_result.valid && i_result.ready) begin
                if (index_queue.size() == 0) begin
                    $error("unexpected result: vertex_index %0d, material_out %0d",
                           i_result.vertex_index, i_result.material_out);
                    o_fail_count++;
                end else begin
                    want = index_queue.pop_front();
                    compare_field("vertex_index", want.vertex_index, i_result.vertex_index);
                    compare_field("is_new", 8'(want.is_new), 8'(i_result.is_new));
                    compare_field("table_full", 8'(want.table_full), 8'(i_result.table_full));
                    compare_field("material_out", want.material_out, i_result.material_out);
                end
            end

            if (i_corner.valid && i_corner.ready) begin
                corner.comp[C_POS_X]    = i_corner.pos_x;
                corner.comp[C_POS_Y]    = i_corner.pos_y;
                corner.comp[C_POS_Z]    = i_corner.pos_z;
                corner.comp[C_NORMAL_X] = i_corner.normal_x;
                corner.comp[C_NORMAL_Y] = i_corner.normal_y;
                corner.comp[C_NORMAL_Z] = i_corner.normal_z;
                corner.comp[C_TEX_U]    = i_corner.tex_u;
                corner.comp[C_TEX_V]    = i_corner.tex_v;
                corner.mat              = i_corner.material_id;
                want = resolve_corner(corner);
                if (want.is_new)
                    o_appends++;
                else if (want.table_full)
                    o_fulls++;
                else
                    o_hits++;
                index_queue.push_back(want);
            end
        end
        o_pending = index_queue.size();
    end

endmodule

// ===== tb/tb_vertex_dedup_indexer_core.sv =====
module tb_vertex_dedup_indexer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vdi_pkg::*;

    localparam int MAX_VERTS    = MAX_VERTICES_DEF;
    localparam int RUN_LIMIT    = 200_000;
    localparam int DRAIN_CYCLES = MAX_VERTS + 16;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [TOL_W-1:0] i_cfg_wdata;

    vdi_in_if  corner_if ();
    vdi_out_if result_if ();

    int chk_fail_count;
    int chk_pending;
    int chk_appends;
    int chk_hits;
    int chk_fulls;

    // Stimulus bookkeeping
    bit               no_gaps;
    t_vtx             sent_hist [$];
    int unsigned      corners_sent;
    int unsigned      sure_misses;
    int unsigned      tol_settings;
    int unsigned      cycle_count;
    logic [TOL_W-1:0] tol_now;

    vertex_dedup_indexer_core #(.MAX_VERTICES(MAX_VERTS)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (corner_if),
        .o_out       (result_if)
    );

    vertex_dedup_checker #(.MAX_VERTICES(MAX_VERTS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_corner     (corner_if),
        .i_result     (result_if),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_appends    (chk_appends),
        .o_hits       (chk_hits),
        .o_fulls      (chk_fulls)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result backpressure, off during the steady stretch
    always @(posedge i_clk) begin
        if (no_gaps)
            result_if.ready <= 1'b1;
        else
            result_if.ready <= ($urandom_range(99) >= 16);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $error("run hit the cycle limit with %0d results outstanding", chk_pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // One corner transfer, with random idle cycles ahead of it
    task automatic send_corner(input t_vtx v);
        while (!no_gaps && $urandom_range(99) < 16) begin
            corner_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        corner_if.valid       <= 1'b1;
        corner_if.pos_x       <= v.comp[C_POS_X];
        corner_if.pos_y       <= v.comp[C_POS_Y];
        corner_if.pos_z       <= v.comp[C_POS_Z];
        corner_if.normal_x    <= v.comp[C_NORMAL_X];
        corner_if.normal_y    <= v.comp[C_NORMAL_Y];
        corner_if.normal_z    <= v.comp[C_NORMAL_Z];
        corner_if.tex_u       <= v.comp[C_TEX_U];
        corner_if.tex_v       <= v.comp[C_TEX_V];
        corner_if.material_id <= v.mat;
        do @(posedge i_clk); while (!corner_if.ready);
        sent_hist.push_back(v);
        corners_sent++;
    endtask

    // Stop sending, wait for every result, then let the chain run empty
    task automatic drain_results();
        corner_if.valid <= 1'b0;
        do @(negedge i_clk); while (chk_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] tol);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tol;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tol_now = tol;
        tol_settings++;
    endtask

    function automatic t_vtx uniform_corner(input logic [CW-1:0] fill,
                                            input logic [MAT_W-1:0] m);
        t_vtx v;
        int   c;
        for (c = 0; c < NCOMP; c++)
            v.comp[c] = fill;
        v.mat = m;
        return v;
    endfunction

    function automatic t_vtx fresh_corner();
        t_vtx v;
        int   c;
        for (c = 0; c < NCOMP; c++)
            v.comp[c] = $urandom;
        v.mat = $urandom_range(255);
        return v;
    endfunction

    // Small integers cluster, so these collide among themselves
    function automatic t_vtx noise_corner();
        t_vtx v;
        int   c;
        for (c = 0; c < NCOMP; c++)
            v.comp[c] = CW'($urandom_range(8)) - CW'(4);
        v.mat = $urandom_range(255);
        return v;
    endfunction

    // Earlier corner nudged per component: mostly inside tolerance, some at the edge
    function automatic t_vtx near_corner();
        t_vtx          v;
        logic [CW-1:0] delta;
        int            c;
        int            pick;
        v = sent_hist[$urandom_range(sent_hist.size() - 1)];
        for (c = 0; c < NCOMP; c++) begin
            pick = $urandom_range(99);
            if (pick < 80)
                delta = (tol_now > 1) ? CW'($urandom_range(tol_now - 1)) : '0;
            else if (pick < 95)
                delta = (tol_now > 0) ? CW'(tol_now - 1) : '0;
            else
                delta = CW'(tol_now) + CW'($urandom_range(1));
            if ($urandom_range(1))
                delta = -delta;
            v.comp[c] = v.comp[c] + delta;
        end
        v.mat = $urandom_range(255);
        return v;
    endfunction

    // Random corners: fresh, noise, otherwise near an earlier corner
    task automatic send_mix(input int n, input int fresh_pct);
        int   k;
        int   pick;
        t_vtx v;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < fresh_pct)
                v = fresh_corner();
            else if (pick < fresh_pct + 10)
                v = noise_corner();
            else
                v = near_corner();
            if (pick < fresh_pct || tol_now == 0)
                sure_misses++;
            send_corner(v);
        end
    endtask

    initial begin
        t_vtx v;
        int   c;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        corner_if.valid       = 1'b0;
        corner_if.pos_x       = '0;
        corner_if.pos_y       = '0;
        corner_if.pos_z       = '0;
        corner_if.normal_x    = '0;
        corner_if.normal_y    = '0;
        corner_if.normal_z    = '0;
        corner_if.tex_u       = '0;
        corner_if.tex_v       = '0;
        corner_if.material_id = '0;
        result_if.ready       = 1'b0;
        no_gaps               = 1'b0;
        tol_now               = TOL_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners at the reset tolerance
        send_corner(uniform_corner(32'h8000_0000, 8'd0));
        send_corner(uniform_corner(32'h7FFF_FFFF, 8'd255));
        send_corner(uniform_corner(32'h8000_0000, 8'd255));
        send_corner(uniform_corner(32'h0000_0000, 8'd1));
        v = uniform_corner(32'h0, 8'd2);
        v.comp[C_POS_X] = 32'd654;
        send_corner(v);
        v.comp[C_POS_X] = 32'd655;
        send_corner(v);
        v = uniform_corner(32'h0, 8'd3);
        v.comp[C_TEX_V] = -32'sd654;
        send_corner(v);
        v.comp[C_TEX_V] = -32'sd655;
        send_corner(v);
        send_corner(uniform_corner(32'hFFFF_FFFF, 8'd128));
        send_corner(uniform_corner(32'h7FFF_FFFF - 32'd654, 8'd127));
        v = uniform_corner(32'h0, 8'hAA);
        for (c = 0; c < NCOMP; c++)
            v.comp[c] = 32'h1 << (4 * c);
        send_corner(v);
        // Each component alone sitting exactly at the tolerance
        for (c = 0; c < NCOMP; c++) begin
            v = uniform_corner(32'h0, 8'h55);
            v.comp[c] = 32'd655;
            send_corner(v);
        end
        drain_results();

        // Zero tolerance: even an exact repeat misses
        set_tolerance('0);
        send_corner(uniform_corner(32'h0000_0000, 8'd7));
        send_mix(60, 20);
        drain_results();

        // Widest tolerance, no idle cycles on either side
        set_tolerance('1);
        no_gaps = 1'b1;
        send_mix(50, 20);
        drain_results();
        no_gaps = 1'b0;

        set_tolerance(16'd1);
        send_mix(50, 20);
        drain_results();

        set_tolerance(TOL_W'($urandom_range(65534, 2)));
        send_mix(50, 20);
        drain_results();

        // Fill the table, then keep going with it full
        set_tolerance(TOL_W'($urandom_range(4000, 200)));
        while (sure_misses < MAX_VERTS + 4)
            send_mix(1, 80);
        send_mix(30, 20);
        drain_results();

        $display("Sent %0d corners across %0d tolerance settings, table filled to capacity.",
                 corners_sent, tol_settings + 1);
        $display("Checked %0d appends, %0d matches and %0d table-full misses.",
                 chk_appends, chk_hits, chk_fulls);
        if (chk_fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
